// ===== sv/aes_pkg.sv =====
// aes-128 package: s-box table, round helpers and shared constants
// no dependencies
package aes_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;
    localparam int ROUNDS  = 10;

    typedef logic [BLOCK_W-1:0] block_t;

    typedef enum logic [0:0]
    {
        REG_KEY_HI = 1'b0,
        REG_KEY_LO = 1'b1
    } reg_idx_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] RCON [ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte k of the block sits at bits 127-8k
    function automatic logic [7:0] get_byte(input block_t b, input int k);
        return b[BLOCK_W-1-8*k -: 8];
    endfunction

    function automatic block_t sub_shift(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[BLOCK_W-1-8*(c*4+r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
            end
        end
        return t;
    endfunction

    function automatic block_t mix_columns(input block_t s);
        block_t t;
        logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, c*4);
            a1 = get_byte(s, c*4+1);
            a2 = get_byte(s, c*4+2);
            a3 = get_byte(s, c*4+3);
            x0 = xtime(a0);
            x1 = xtime(a1);
            x2 = xtime(a2);
            x3 = xtime(a3);
            t[BLOCK_W-1-8*(c*4)   -: 8] = x0 ^ x1 ^ a1 ^ a2 ^ a3;
            t[BLOCK_W-1-8*(c*4+1) -: 8] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
            t[BLOCK_W-1-8*(c*4+2) -: 8] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
            t[BLOCK_W-1-8*(c*4+3) -: 8] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
        end
        return t;
    endfunction

    // next round key from the previous one
    function automatic block_t next_key(input block_t k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        t = t ^ {rc, 24'h0};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ===== sv/aes_stream_if.sv =====
// valid/ready channel carrying one 128-bit block as two halves
// depends on aes_pkg for the half width
interface aes_stream_if
    import aes_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] lo;

    modport source (output valid, output hi, output lo, input ready);
    modport sink (input valid, input hi, input lo, output ready);
endinterface

// ===== sv/aes128_block_encrypt.sv =====
// aes-128 encryption: initial key add stage and ten round stages, the last one drives the output
// the result is registered in the key add stage and then in each round stage in turn before it is valid
// one block per cycle while the pipeline advances; round keys are expanded once per key write, in a sweep after it
// the pipeline advances as one unit while the output register is empty or taken
// reset clears valid bits and the key to zero; round keys follow the all-zero key
module aes128_block_encrypt
    import aes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [HALF_W-1:0] cfg_data,
    aes_stream_if.sink        plain,
    aes_stream_if.source      cipher
);

    localparam int STAGES = ROUNDS + 1;

    logic [HALF_W-1:0] key_hi_reg, key_lo_reg;
    block_t            rk_reg [STAGES];
    logic [3:0]        kx_cnt_reg;
    block_t            st_reg [STAGES];
    logic [STAGES-1:0] vld_reg;
    logic              advance;

    // round key sweep restarts on each key write; user must keep block idle then (not enforced)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
            kx_cnt_reg <= 4'd0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_KEY_HI: key_hi_reg <= cfg_data;
                REG_KEY_LO: key_lo_reg <= cfg_data;
                default: ;
            endcase
            kx_cnt_reg <= 4'd0;
        end
        else if (kx_cnt_reg <= 4'(ROUNDS))
        begin
            kx_cnt_reg <= kx_cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        rk_reg[0] <= {key_hi_reg, key_lo_reg};
        for (int i = 1; i < STAGES; i++)
        begin
            if (kx_cnt_reg == 4'(i))
            begin
                rk_reg[i] <= next_key(rk_reg[i-1], RCON[i-1]);
            end
        end
    end

    assign advance     = !cipher.valid || cipher.ready;
    assign plain.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], plain.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg[0] <= {plain.hi, plain.lo} ^ rk_reg[0];
            for (int i = 1; i < ROUNDS; i++)
            begin
                st_reg[i] <= mix_columns(sub_shift(st_reg[i-1])) ^ rk_reg[i];
            end
            st_reg[ROUNDS] <= sub_shift(st_reg[ROUNDS-1]) ^ rk_reg[ROUNDS];
        end
    end

    assign cipher.valid = vld_reg[STAGES-1];
    assign cipher.hi    = st_reg[ROUNDS][BLOCK_W-1:HALF_W];
    assign cipher.lo    = st_reg[ROUNDS][HALF_W-1:0];

endmodule
